FILE: rtl/core/rlss_pkg.sv
`timescale 1ns / 1ps

package rlss_pkg;

  // Default geometry of the sequencer.
  localparam int PATTERN_BITS_DEF = 16;
  localparam int NUM_RHYTHMS_DEF  = 8;

  // Fixed widths of the channel fields.
  localparam int CMD_W   = 2;
  localparam int PROB_W  = 16;
  localparam int POS_W   = 4;
  localparam int LEN_W   = 5;
  localparam int VALUE_W = 16;
  localparam int CNT_W   = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVOLVE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE = 2'd2;

  // Command codes carried by one item.
  typedef enum logic [CMD_W-1:0] {
    CMD_STEP    = 2'd0,
    CMD_RESTORE = 2'd1,
    CMD_LOAD    = 2'd2
  } cmd_t;

  // Mode bits held by the configuration registers.
  typedef struct packed {
    logic rotate;
    logic evolve;
    logic write_en;
  } mode_t;

  // Period of each rhythm counter; the table repeats every eight counters.
  function automatic logic [CNT_W-1:0] rhythm_period(input logic [2:0] idx);
    logic [CNT_W-1:0] p;
    unique case (idx)
      3'd0:    p = 5'd16;
      3'd1:    p = 5'd12;
      3'd2:    p = 5'd9;
      3'd3:    p = 5'd7;
      3'd4:    p = 5'd5;
      3'd5:    p = 5'd3;
      3'd6:    p = 5'd6;
      default: p = 5'd4;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/rlss_rhythm.sv
`timescale 1ns / 1ps

module rlss_rhythm import rlss_pkg::*; #(
  parameter int NUM_RHYTHMS = NUM_RHYTHMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  output logic fire
);

  logic [CNT_W-1:0] cnt_r   [NUM_RHYTHMS];
  logic [CNT_W-1:0] cnt_nxt [NUM_RHYTHMS];
  logic [NUM_RHYTHMS-1:0] wrap;

  // Each counter wraps to zero when it reaches its period.
  for (genvar i = 0; i < NUM_RHYTHMS; i++) begin : g_cnt
    logic [CNT_W:0] inc;
    assign inc = {1'b0, cnt_r[i]} + {{CNT_W{1'b0}}, 1'b1};
    assign wrap[i] = inc >= {1'b0, rhythm_period(3'(i % 8))};
    assign cnt_nxt[i] = wrap[i] ? '0 : inc[CNT_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else if (step_en) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // The pattern rotates when any counter wraps on this step.
  assign fire = |wrap;

endmodule

FILE: rtl/core/rlss_next.sv
`timescale 1ns / 1ps

module rlss_next import rlss_pkg::*; #(
  parameter int PATTERN_BITS = PATTERN_BITS_DEF
) (
  input  logic [PATTERN_BITS-1:0] pattern,
  input  logic [PATTERN_BITS-1:0] seed,
  input  mode_t                   mode,
  input  logic                    fire,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [PROB_W-1:0]       change_prob,
  input  logic [PROB_W-1:0]       bias_prob,
  input  logic [PROB_W-1:0]       draw_gate,
  input  logic [PROB_W-1:0]       draw_bit,
  input  logic [POS_W-1:0]        draw_pos,
  input  logic [VALUE_W-1:0]      seed_pattern,
  input  logic [LEN_W-1:0]        out_length,
  output logic [PATTERN_BITS-1:0] pattern_nxt,
  output logic [PATTERN_BITS-1:0] seed_nxt,
  output logic                    poly_step,
  output logic [VALUE_W-1:0]      pattern_value,
  output logic                    pulse_bit,
  output logic [VALUE_W-1:0]      pattern_bits
);

  localparam int MaxLen = (PATTERN_BITS < VALUE_W) ? PATTERN_BITS : VALUE_W;
  localparam int PosW   = $clog2(PATTERN_BITS);
  localparam int ExtW   = PATTERN_BITS + VALUE_W;

  logic                    mutate;
  logic                    hit;
  logic [PROB_W+3:0]       gate_x10;
  logic                    new_bit;
  logic [PATTERN_BITS-1:0] shifted;
  logic [PATTERN_BITS-1:0] rotated;
  logic [6:0]              pos_mod;
  logic [PATTERN_BITS-1:0] normal_pat;
  logic [ExtW-1:0]         seed_ext;
  logic [ExtW-1:0]         pat_ext;
  logic [ExtW-1:0]         pat_shr;
  logic [LEN_W-1:0]        len;
  logic [6:0]              shamt;
  logic [VALUE_W:0]        len_mask;

  // Mutation gate: evolving mode compares ten times the draw.
  assign mutate   = mode.write_en | mode.evolve;
  assign gate_x10 = ({4'b0, draw_gate} << 3) + ({4'b0, draw_gate} << 1);
  assign hit      = mode.evolve ? (gate_x10 < {4'b0, change_prob})
                                : (draw_gate < change_prob);
  assign new_bit  = (mutate && hit) ? (draw_bit < bias_prob) : pattern[PATTERN_BITS-1];
  assign shifted  = {pattern[PATTERN_BITS-2:0], new_bit};
  assign rotated  = {pattern[PATTERN_BITS-2:0], pattern[PATTERN_BITS-1]};

  // Reduce the drawn position into the pattern width by repeated subtraction.
  always_comb begin
    pos_mod = {3'b0, draw_pos};
    for (int k = 0; k < 4; k++) begin
      if (pos_mod >= 7'(PATTERN_BITS)) begin
        pos_mod = pos_mod - 7'(PATTERN_BITS);
      end
    end
  end

  // Normal step, with a single bit injected into an all-zero pattern when mutation is on.
  always_comb begin
    normal_pat = shifted;
    if (mutate && (shifted == '0)) begin
      normal_pat = '0;
      normal_pat[pos_mod[PosW-1:0]] = 1'b1;
    end
  end

  assign seed_ext = ExtW'(seed_pattern);

  // Command decode.
  always_comb begin
    pattern_nxt = pattern;
    seed_nxt    = seed;
    poly_step   = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_STEP: begin
        if (mode.rotate) begin
          poly_step   = 1'b1;
          pattern_nxt = fire ? rotated : pattern;
        end else begin
          pattern_nxt = normal_pat;
        end
      end
      CMD_RESTORE: begin
        pattern_nxt = seed;
      end
      CMD_LOAD: begin
        pattern_nxt = seed_ext[PATTERN_BITS-1:0];
        seed_nxt    = seed_ext[PATTERN_BITS-1:0];
      end
      default: begin
        pattern_nxt = pattern;
      end
    endcase
  end

  // Output length is clamped to the range one to MaxLen.
  always_comb begin
    len = out_length;
    if (len == '0) begin
      len = LEN_W'(1);
    end else if (len > LEN_W'(MaxLen)) begin
      len = LEN_W'(MaxLen);
    end
  end

  // Top bits of the new pattern, most significant first.
  assign pat_ext       = ExtW'(pattern_nxt);
  assign shamt         = 7'(PATTERN_BITS) - {2'b0, len};
  assign pat_shr       = pat_ext >> shamt;
  assign len_mask      = ({{VALUE_W{1'b0}}, 1'b1} << len) - {{VALUE_W{1'b0}}, 1'b1};
  assign pattern_value = pat_shr[VALUE_W-1:0] & len_mask[VALUE_W-1:0];
  assign pulse_bit     = pattern_nxt[PATTERN_BITS-1];
  assign pattern_bits  = pat_ext[VALUE_W-1:0];

endmodule

FILE: rtl/core/random_looping_shift_sequencer.sv
`timescale 1ns / 1ps

// Random looping shift sequencer.
// Input channel (in_valid/in_ready) carries one command per transfer: a clock
// step, a seed restore or a seed load, together with the probabilities and
// random draws that a step uses. Output channel (out_valid/out_ready) returns
// one result per command: the top out_length bits of the updated pattern, its
// top bit and the whole pattern.
// Mode registers are written through cfg_wr_en/cfg_index/cfg_wdata with no
// wait; they must only change while the block is idle.
// A result passes through the input register, then the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// update of pattern, seed and rhythm counters is a single pass of logic
// between the two registers.
// Reset clears the pattern, the seed, the rhythm counters, the mode registers
// and both valid flags. When the receiver stalls, the result register holds
// and one more item waits in the input register; in_ready then drops until
// the result is taken.
module random_looping_shift_sequencer import rlss_pkg::*; #(
  parameter int PATTERN_BITS = PATTERN_BITS_DEF,
  parameter int NUM_RHYTHMS  = NUM_RHYTHMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [PROB_W-1:0]     in_change_prob,
  input  logic [PROB_W-1:0]     in_bias_prob,
  input  logic [PROB_W-1:0]     in_draw_gate,
  input  logic [PROB_W-1:0]     in_draw_bit,
  input  logic [POS_W-1:0]      in_draw_pos,
  input  logic [VALUE_W-1:0]    in_seed_pattern,
  input  logic [LEN_W-1:0]      in_out_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_W-1:0]    out_pattern_value,
  output logic                  out_pulse_bit,
  output logic [VALUE_W-1:0]    out_pattern_bits
);

  mode_t mode_r;

  logic                    s1_valid_r;
  logic [CMD_W-1:0]        s1_cmd_r;
  logic [PROB_W-1:0]       s1_change_r;
  logic [PROB_W-1:0]       s1_bias_r;
  logic [PROB_W-1:0]       s1_gate_r;
  logic [PROB_W-1:0]       s1_bit_r;
  logic [POS_W-1:0]        s1_pos_r;
  logic [VALUE_W-1:0]      s1_seed_r;
  logic [LEN_W-1:0]        s1_len_r;

  logic [PATTERN_BITS-1:0] pattern_r;
  logic [PATTERN_BITS-1:0] seed_r;
  logic [PATTERN_BITS-1:0] pattern_nxt;
  logic [PATTERN_BITS-1:0] seed_nxt;

  logic                    out_valid_r;
  logic [VALUE_W-1:0]      value_r;
  logic                    pulse_r;
  logic [VALUE_W-1:0]      bits_r;
  logic [VALUE_W-1:0]      value_nxt;
  logic                    pulse_nxt;
  logic [VALUE_W-1:0]      bits_nxt;

  logic                    fire;
  logic                    poly_step;
  logic                    commit;
  logic                    in_xfer;

  // Mode registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROTATE_MODE:  mode_r.rotate   <= cfg_wdata[0];
        REG_EVOLVE_MODE:  mode_r.evolve   <= cfg_wdata[0];
        REG_WRITE_ENABLE: mode_r.write_en <= cfg_wdata[0];
        default:          mode_r          <= mode_r;
      endcase
    end
  end

  // The held item commits when the result register is free or being drained.
  assign commit   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || commit;
  assign in_xfer  = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r    <= in_cmd;
      s1_change_r <= in_change_prob;
      s1_bias_r   <= in_bias_prob;
      s1_gate_r   <= in_draw_gate;
      s1_bit_r    <= in_draw_bit;
      s1_pos_r    <= in_draw_pos;
      s1_seed_r   <= in_seed_pattern;
      s1_len_r    <= in_out_length;
    end
  end

  rlss_rhythm #(
    .NUM_RHYTHMS (NUM_RHYTHMS)
  ) u_rhythm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (commit && poly_step),
    .fire    (fire)
  );

  rlss_next #(
    .PATTERN_BITS (PATTERN_BITS)
  ) u_next (
    .pattern       (pattern_r),
    .seed          (seed_r),
    .mode          (mode_r),
    .fire          (fire),
    .cmd           (s1_cmd_r),
    .change_prob   (s1_change_r),
    .bias_prob     (s1_bias_r),
    .draw_gate     (s1_gate_r),
    .draw_bit      (s1_bit_r),
    .draw_pos      (s1_pos_r),
    .seed_pattern  (s1_seed_r),
    .out_length    (s1_len_r),
    .pattern_nxt   (pattern_nxt),
    .seed_nxt      (seed_nxt),
    .poly_step     (poly_step),
    .pattern_value (value_nxt),
    .pulse_bit     (pulse_nxt),
    .pattern_bits  (bits_nxt)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      seed_r    <= '0;
    end else if (commit) begin
      pattern_r <= pattern_nxt;
      seed_r    <= seed_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      value_r <= value_nxt;
      pulse_r <= pulse_nxt;
      bits_r  <= bits_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pattern_value = value_r;
  assign out_pulse_bit     = pulse_r;
  assign out_pattern_bits  = bits_r;

`ifndef SYNTHESIS
  // State only moves when an item commits.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> ($stable(pattern_r) && $stable(seed_r)))
    else $error("pattern or seed changed without a commit");

  // A load leaves the pattern equal to the new seed.
  a_load_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (s1_cmd_r == CMD_LOAD)) |=> (pattern_r == seed_r))
    else $error("load did not set pattern and seed alike");

  // A mutating step never leaves an all-zero pattern.
  a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (s1_cmd_r == CMD_STEP) && !mode_r.rotate &&
     (mode_r.write_en || mode_r.evolve)) |=> (pattern_r != '0))
    else $error("mutating step left the pattern all zero");

  // Every commit presents a result in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item produced no result");

  // The result's top bit matches the pattern it was taken from.
  a_pulse_match: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (pulse_r == pattern_r[PATTERN_BITS-1]))
    else $error("pulse bit does not match the pattern top bit");
`endif

endmodule
